[rtl/floppy_command_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// Floppy command sequencer assertion macros
// Shared assertion wrappers. They compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef FLOPPY_COMMAND_SEQUENCER_DEFINES_SVH
`define FLOPPY_COMMAND_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define FCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Same-cycle implication.
`define FCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication.
`define FCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`else

`define FCS_ASSERT(lbl, clk, rst_n, prop)
`define FCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/fcs_pkg.sv]
// ----------------------------------------------------------------------------
// Floppy command sequencer package
// Field widths, event and phase codes, configuration and result types.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int CMD_W     = 3;
  localparam int BLOCK_W   = 12;
  localparam int SECT_W    = 5;
  localparam int ADDR_W    = 24;
  localparam int STATUS_W  = 8;
  localparam int TIMER_W   = 16;
  localparam int RETRY_W   = 3;
  localparam int CYL_W     = 7;
  localparam int CFG_IDX_W = 3;

  // Block quotient by sectors per track: at least eight sectors per track,
  // so a 12-bit block gives at most nine quotient bits.
  localparam int QUOT_W       = 9;
  // Upper bound of log2 of the sectors per track (at most 36).
  localparam int SPT_MAX_LOG2 = 6;

  // Status byte 0 checks.
  localparam logic [STATUS_W-1:0] SEEK_ST_MASK = 8'hf8;
  localparam logic [STATUS_W-1:0] SEEK_ST_OK   = 8'h20;
  localparam logic [STATUS_W-1:0] XFER_ST_MASK = 8'hd8;

  // Configuration reset values.
  localparam logic [TIMER_W-1:0] SPINUP_RST      = 16'd250;
  localparam logic [TIMER_W-1:0] RESET_TMO_RST   = 16'd500;
  localparam logic [TIMER_W-1:0] RECAL_TMO_RST   = 16'd5000;
  localparam logic [TIMER_W-1:0] SEEK_TMO_RST    = 16'd4000;
  localparam logic [TIMER_W-1:0] XFER_TMO_RST    = 16'd2000;
  localparam logic [TIMER_W-1:0] IDLE_OFF_RST    = 16'd5000;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 3'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_RD_REQ = 3'd0,
    CMD_WR_REQ = 3'd1,
    CMD_INTR   = 3'd2,
    CMD_TMO    = 3'd3,
    CMD_CLOSE  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    PH_OFF   = 3'd0,
    PH_ON    = 3'd1,
    PH_RESET = 3'd2,
    PH_RECAL = 3'd3,
    PH_SEEK  = 3'd4,
    PH_XFER  = 3'd5,
    PH_READY = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_READ  = 2'd1,
    PEND_WRITE = 2'd2
  } pend_e;

  typedef enum logic [1:0] {
    MOTOR_NONE  = 2'd0,
    MOTOR_OFF   = 2'd1,
    MOTOR_ON    = 2'd2,
    MOTOR_PULSE = 2'd3
  } motor_e;

  typedef enum logic [1:0] {
    TMR_LEAVE = 2'd0,
    TMR_STOP  = 2'd1,
    TMR_LOAD  = 2'd2
  } tmr_e;

  typedef enum logic [2:0] {
    ISSUE_NONE  = 3'd0,
    ISSUE_RECAL = 3'd1,
    ISSUE_SEEK  = 3'd2,
    ISSUE_READ  = 3'd3,
    ISSUE_WRITE = 3'd4
  } issue_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_IO    = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPINUP      = 3'd0,
    CFG_RESET_TMO   = 3'd1,
    CFG_RECAL_TMO   = 3'd2,
    CFG_SEEK_TMO    = 3'd3,
    CFG_XFER_TMO    = 3'd4,
    CFG_IDLE_OFF    = 3'd5,
    CFG_RETRY_LIMIT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TIMER_W-1:0] spinup_ms;
    logic [TIMER_W-1:0] reset_timeout_ms;
    logic [TIMER_W-1:0] recal_timeout_ms;
    logic [TIMER_W-1:0] seek_timeout_ms;
    logic [TIMER_W-1:0] xfer_timeout_ms;
    logic [TIMER_W-1:0] idle_off_ms;
    logic [RETRY_W-1:0] retry_limit;
  } cfg_t;

  // One accepted event plus the block quotient computed on the way in.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [BLOCK_W-1:0]  block;
    logic [SECT_W-1:0]   sectors;
    logic [ADDR_W-1:0]   dma_addr;
    logic [STATUS_W-1:0] status;
    logic [QUOT_W-1:0]   quot;
  } item_t;

  typedef struct packed {
    logic [2:0]          phase;
    logic [1:0]          motor_write;
    logic [1:0]          timer_action;
    logic [TIMER_W-1:0]  timer_ms;
    logic [2:0]          issue;
    logic                head;
    logic [CYL_W-1:0]    cylinder;
    logic [SECT_W-1:0]   sector;
    logic [ADDR_W-1:0]   xfer_addr;
    logic [SECT_W-1:0]   xfer_sectors;
    logic                wake;
    logic [1:0]          error;
  } res_t;

endpackage

[rtl/fcs_blk_div.sv]
// ----------------------------------------------------------------------------
// Block divider
// Divides the block number by the sectors per track with a reciprocal multiply.
// ----------------------------------------------------------------------------
module fcs_blk_div #(
  parameter int SECTORS_PER_TRACK = 18
) (
  input  logic [fcs_pkg::BLOCK_W-1:0] block_i,
  output logic [fcs_pkg::QUOT_W-1:0]  quot_o
);
  import fcs_pkg::*;

  // With a shift of BLOCK_W plus log2 of the largest divisor, the rounded-up
  // reciprocal gives the exact floor quotient for every 12-bit block.
  localparam int RECIP_SHIFT = BLOCK_W + SPT_MAX_LOG2;
  localparam int RECIP_MULT  = (2 ** RECIP_SHIFT + SECTORS_PER_TRACK - 1) / SECTORS_PER_TRACK;
  localparam int MULT_W      = RECIP_SHIFT - 2;
  localparam int PROD_W      = BLOCK_W + MULT_W;

  logic [PROD_W-1:0] prod;

  assign prod   = PROD_W'(block_i) * PROD_W'(RECIP_MULT);
  assign quot_o = prod[RECIP_SHIFT +: QUOT_W];

endmodule

[rtl/fcs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Timer values and retry limit, written through the configuration channel.
// ----------------------------------------------------------------------------
module fcs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [fcs_pkg::CFG_IDX_W-1:0] wr_idx_i,
  input  logic [fcs_pkg::TIMER_W-1:0]   wr_data_i,
  output fcs_pkg::cfg_t                 cfg_o
);
  import fcs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spinup_ms        <= SPINUP_RST;
      cfg_q.reset_timeout_ms <= RESET_TMO_RST;
      cfg_q.recal_timeout_ms <= RECAL_TMO_RST;
      cfg_q.seek_timeout_ms  <= SEEK_TMO_RST;
      cfg_q.xfer_timeout_ms  <= XFER_TMO_RST;
      cfg_q.idle_off_ms      <= IDLE_OFF_RST;
      cfg_q.retry_limit      <= RETRY_LIMIT_RST;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        CFG_SPINUP:      cfg_q.spinup_ms        <= wr_data_i;
        CFG_RESET_TMO:   cfg_q.reset_timeout_ms <= wr_data_i;
        CFG_RECAL_TMO:   cfg_q.recal_timeout_ms <= wr_data_i;
        CFG_SEEK_TMO:    cfg_q.seek_timeout_ms  <= wr_data_i;
        CFG_XFER_TMO:    cfg_q.xfer_timeout_ms  <= wr_data_i;
        CFG_IDLE_OFF:    cfg_q.idle_off_ms      <= wr_data_i;
        CFG_RETRY_LIMIT: cfg_q.retry_limit      <= wr_data_i[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/fcs_seq_core.sv]
// ----------------------------------------------------------------------------
// Sequencer core
// Holds the drive phase and request, decides each event in one pass.
// ----------------------------------------------------------------------------
module fcs_seq_core #(
  parameter int SECTORS_PER_TRACK = 18,
  parameter int HEADS             = 2,
  parameter int CYLINDERS         = 80
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  fcs_pkg::item_t item_i,
  input  fcs_pkg::cfg_t  cfg_i,
  output fcs_pkg::res_t  res_o
);
  import fcs_pkg::*;

  localparam int TOTAL_BLOCKS = HEADS * CYLINDERS * SECTORS_PER_TRACK;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ON,
    ACT_RESET,
    ACT_RECAL,
    ACT_SEEK,
    ACT_XFER,
    ACT_READY,
    ACT_OFF,
    ACT_ERROR,
    ACT_RANGE,
    ACT_STOP
  } act_e;

  phase_e              phase_q, phase_d;
  pend_e               pend_q, pend_d;
  logic [RETRY_W-1:0]  retry_q, retry_d;
  logic                head_q, head_d;
  logic [CYL_W-1:0]    cyl_q, cyl_d;
  logic [SECT_W-1:0]   sect_q, sect_d;
  logic [SECT_W-1:0]   nsect_q, nsect_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;

  act_e                act;
  logic                retry_go;
  logic                out_of_range;
  logic                seek_ok;
  logic                xfer_ok;
  logic [BLOCK_W-1:0]  quot_prod;
  logic [BLOCK_W-1:0]  sect_idx;
  logic [SECT_W-1:0]   item_sect;
  logic                item_head;
  logic [CYL_W-1:0]    item_cyl;
  logic [QUOT_W-1:0]   cyl_full;
  res_t                res;

  // Geometry of the incoming block from its quotient by sectors per track.
  // The quotient times the divisor never exceeds the block, so 12 bits hold it.
  assign quot_prod = BLOCK_W'(item_i.quot) * BLOCK_W'(SECTORS_PER_TRACK);
  assign sect_idx  = item_i.block - quot_prod;
  assign item_sect = SECT_W'(sect_idx + BLOCK_W'(1));
  assign cyl_full  = (HEADS == 2) ? (item_i.quot >> 1) : item_i.quot;
  assign item_head = (HEADS == 2) ? item_i.quot[0] : 1'b0;
  assign item_cyl  = cyl_full[CYL_W-1:0];

  assign out_of_range = {1'b0, item_i.block} >= (BLOCK_W + 1)'(TOTAL_BLOCKS);
  assign seek_ok      = (item_i.status & SEEK_ST_MASK) == SEEK_ST_OK;
  assign xfer_ok      = (item_i.status & XFER_ST_MASK) == '0;

  always_comb begin
    act      = ACT_NONE;
    retry_go = 1'b0;
    pend_d   = pend_q;
    retry_d  = retry_q;
    head_d   = head_q;
    cyl_d    = cyl_q;
    sect_d   = sect_q;
    nsect_d  = nsect_q;
    addr_d   = addr_q;

    case (item_i.cmd)
      CMD_RD_REQ, CMD_WR_REQ: begin
        if (out_of_range) begin
          act = ACT_RANGE;
        end else begin
          pend_d  = (item_i.cmd == CMD_WR_REQ) ? PEND_WRITE : PEND_READ;
          retry_d = '0;
          head_d  = item_head;
          cyl_d   = item_cyl;
          sect_d  = item_sect;
          nsect_d = (item_i.sectors == '0) ? SECT_W'(1) : item_i.sectors;
          addr_d  = item_i.dma_addr;
          act     = (phase_q == PH_OFF) ? ACT_ON : ACT_SEEK;
        end
      end
      CMD_INTR: begin
        if (phase_q inside {PH_RESET, PH_RECAL, PH_SEEK, PH_XFER}) begin
          if (pend_q == PEND_NONE) begin
            act = ACT_STOP;
          end else begin
            case (phase_q)
              PH_RESET: act = ACT_RECAL;
              PH_RECAL: act = seek_ok ? ACT_SEEK : ACT_ERROR;
              PH_SEEK: begin
                if (seek_ok) act = ACT_XFER;
                else retry_go = 1'b1;
              end
              PH_XFER: begin
                if (xfer_ok) act = ACT_READY;
                else retry_go = 1'b1;
              end
              default: act = ACT_NONE;
            endcase
          end
        end
      end
      CMD_TMO: begin
        case (phase_q)
          PH_ON:              act = ACT_RESET;
          PH_RESET, PH_RECAL: act = ACT_ERROR;
          PH_SEEK, PH_XFER:   retry_go = 1'b1;
          PH_READY:           act = ACT_OFF;
          default:            act = ACT_NONE;
        endcase
      end
      CMD_CLOSE: begin
        pend_d = PEND_NONE;
        act    = ACT_OFF;
      end
      default: act = ACT_NONE;
    endcase

    // Failed seek or transfer: go back through a controller reset while
    // retries remain, otherwise give up with an I/O error.
    if (retry_go) begin
      if (retry_q < cfg_i.retry_limit) begin
        retry_d = retry_q + RETRY_W'(1);
        act     = ACT_RESET;
      end else begin
        act = ACT_ERROR;
      end
    end
  end

  always_comb begin
    res     = '0;
    phase_d = phase_q;

    case (act)
      ACT_ON: begin
        phase_d          = PH_ON;
        res.motor_write  = MOTOR_ON;
        res.timer_action = TMR_LOAD;
        res.timer_ms     = cfg_i.spinup_ms;
      end
      ACT_RESET: begin
        phase_d          = PH_RESET;
        res.motor_write  = MOTOR_PULSE;
        res.timer_action = TMR_LOAD;
        res.timer_ms     = cfg_i.reset_timeout_ms;
      end
      ACT_RECAL: begin
        phase_d          = PH_RECAL;
        res.timer_action = TMR_LOAD;
        res.timer_ms     = cfg_i.recal_timeout_ms;
        res.issue        = ISSUE_RECAL;
      end
      ACT_SEEK: begin
        phase_d          = PH_SEEK;
        res.timer_action = TMR_LOAD;
        res.timer_ms     = cfg_i.seek_timeout_ms;
        res.issue        = ISSUE_SEEK;
        res.head         = head_d;
        res.cylinder     = cyl_d;
      end
      ACT_XFER: begin
        phase_d          = PH_XFER;
        res.timer_action = TMR_LOAD;
        res.timer_ms     = cfg_i.xfer_timeout_ms;
        res.issue        = (pend_d == PEND_WRITE) ? ISSUE_WRITE : ISSUE_READ;
        res.head         = head_d;
        res.cylinder     = cyl_d;
        res.sector       = sect_d;
        res.xfer_addr    = addr_d;
        res.xfer_sectors = nsect_d;
      end
      ACT_READY: begin
        phase_d          = PH_READY;
        res.wake         = 1'b1;
        res.timer_action = TMR_LOAD;
        res.timer_ms     = cfg_i.idle_off_ms;
      end
      ACT_OFF: begin
        phase_d          = PH_OFF;
        res.motor_write  = MOTOR_OFF;
        res.timer_action = TMR_STOP;
      end
      ACT_ERROR: begin
        phase_d          = PH_OFF;
        res.motor_write  = MOTOR_OFF;
        res.timer_action = TMR_STOP;
        res.wake         = 1'b1;
        res.error        = ERR_IO;
      end
      ACT_RANGE: begin
        res.wake  = 1'b1;
        res.error = ERR_RANGE;
      end
      ACT_STOP: res.timer_action = TMR_STOP;
      default: ;
    endcase

    res.phase = phase_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OFF;
      pend_q  <= PEND_NONE;
      retry_q <= '0;
      head_q  <= 1'b0;
      cyl_q   <= '0;
      sect_q  <= '0;
      nsect_q <= '0;
      addr_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      retry_q <= retry_d;
      head_q  <= head_d;
      cyl_q   <= cyl_d;
      sect_q  <= sect_d;
      nsect_q <= nsect_d;
      addr_q  <= addr_d;
    end
  end

endmodule

[rtl/floppy_command_sequencer.sv]
// ----------------------------------------------------------------------------
// Floppy command sequencer
// An event transfer goes into the input register, then its result into the
// result register; one event per cycle unless the result channel stalls.
// Rate is set by the single decision pass between the two registers.
// Reset (rst_ni low, asynchronous) empties both stages, puts the drive in the
// off phase with no request and loads the default timer and retry settings.
// ----------------------------------------------------------------------------
`include "floppy_command_sequencer_defines.svh"

module floppy_command_sequencer #(
  parameter int SECTORS_PER_TRACK = 18,
  parameter int HEADS             = 2,
  parameter int CYLINDERS         = 80
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // Event channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fcs_pkg::CMD_W-1:0]     cmd_i,
  input  logic [fcs_pkg::BLOCK_W-1:0]   block_i,
  input  logic [fcs_pkg::SECT_W-1:0]    sectors_i,
  input  logic [fcs_pkg::ADDR_W-1:0]    dma_addr_i,
  input  logic [fcs_pkg::STATUS_W-1:0]  status_i,

  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    phase_o,
  output logic [1:0]                    motor_write_o,
  output logic [1:0]                    timer_action_o,
  output logic [fcs_pkg::TIMER_W-1:0]   timer_ms_o,
  output logic [2:0]                    issue_o,
  output logic                          head_o,
  output logic [fcs_pkg::CYL_W-1:0]     cylinder_o,
  output logic [fcs_pkg::SECT_W-1:0]    sector_o,
  output logic [fcs_pkg::ADDR_W-1:0]    xfer_addr_o,
  output logic [fcs_pkg::SECT_W-1:0]    xfer_sectors_o,
  output logic                          wake_o,
  output logic [1:0]                    error_o,

  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fcs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fcs_pkg::TIMER_W-1:0]   cfg_data_i
);
  import fcs_pkg::*;

  // The design is a two-register pipeline. An event transfer lands in the
  // input register together with the block quotient by sectors per track,
  // which is a constant reciprocal multiply done on the way in. When the
  // result register is free, the core decides the event from that register
  // and its own state, and its result is registered as the core state is
  // updated at the same edge. So the following event, already waiting in
  // the input register, always sees the state left by the one before it.

  logic  in_vld_q;
  item_t item_q;
  logic  out_vld_q;
  res_t  res_q;

  logic  in_xfer;
  logic  out_hold;
  logic  fire;
  logic [QUOT_W-1:0] quot;
  cfg_t  cfg;
  res_t  res;

  // The result register frees up when it is empty or its result is taken.
  // The input register only stalls when it is full and cannot move on.
  assign out_hold   = out_vld_q & out_stall_i;
  assign fire       = in_vld_q & ~out_hold;
  assign in_stall_o = in_vld_q & out_hold;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // Configuration is always accepted; writes must arrive only while idle, and the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  fcs_blk_div #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
  ) u_blk_div (
    .block_i (block_i),
    .quot_o  (quot)
  );

  fcs_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i & cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  fcs_seq_core #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .HEADS             (HEADS),
    .CYLINDERS         (CYLINDERS)
  ) u_seq_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_xfer | (in_vld_q & ~fire);
      out_vld_q <= fire | out_hold;
    end
  end

  // Stage payloads; they load only on a transfer into the stage.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.cmd      <= cmd_i;
      item_q.block    <= block_i;
      item_q.sectors  <= sectors_i;
      item_q.dma_addr <= dma_addr_i;
      item_q.status   <= status_i;
      item_q.quot     <= quot;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign phase_o        = res_q.phase;
  assign motor_write_o  = res_q.motor_write;
  assign timer_action_o = res_q.timer_action;
  assign timer_ms_o     = res_q.timer_ms;
  assign issue_o        = res_q.issue;
  assign head_o         = res_q.head;
  assign cylinder_o     = res_q.cylinder;
  assign sector_o       = res_q.sector;
  assign xfer_addr_o    = res_q.xfer_addr;
  assign xfer_sectors_o = res_q.xfer_sectors;
  assign wake_o         = res_q.wake;
  assign error_o        = res_q.error;

  // A waiting event with a free result register produces a result next cycle.
  `FCS_ASSERT_NEXT(a_fire_to_out, clk_i, rst_ni, in_vld_q && !out_hold, out_vld_q)

  // A rejected block issues nothing and leaves the timer alone.
  `FCS_ASSERT_IMPL(a_range_quiet, clk_i, rst_ni, out_valid_o && error_o == ERR_RANGE, issue_o == ISSUE_NONE && timer_action_o == TMR_LEAVE)

  // A data command always comes with the transfer phase and a real sector.
  `FCS_ASSERT_IMPL(a_xfer_fields, clk_i, rst_ni, out_valid_o && (issue_o == ISSUE_READ || issue_o == ISSUE_WRITE), phase_o == PH_XFER && sector_o != 0 && xfer_sectors_o != 0)

  // A clean release of the requester only happens when the transfer is done.
  `FCS_ASSERT_IMPL(a_wake_ready, clk_i, rst_ni, out_valid_o && wake_o && error_o == ERR_NONE, phase_o == PH_READY)

endmodule

[bench/tb_floppy_command_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Floppy command sequencer testbench
// Drives request, interrupt, timeout and close events into the sequencer and
// checks each result against an in-bench model of the drive phases, retries
// and disk geometry, or against a typed-in result. A short table of directed
// events comes first. Random traffic follows, mostly shaped to walk full
// transfers, under three register settings and three idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_floppy_command_sequencer;
  import fcs_pkg::*;

  // Disk geometry. The block is built with its default parameters.
  localparam int SPT         = 18;
  localparam int DRIVE_HEADS = 2;
  localparam int CYLS        = 80;
  localparam int PER_CYL     = SPT * DRIVE_HEADS;
  localparam int DISK_BLOCKS = PER_CYL * CYLS;
  localparam int BLOCK_MAX   = (1 << BLOCK_W) - 1;

  // Event codes that the block does not decode.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PER_PASS = 540;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      cmd_i = '0;
  logic [BLOCK_W-1:0]    block_i = '0;
  logic [SECT_W-1:0]     sectors_i = '0;
  logic [ADDR_W-1:0]     dma_addr_i = '0;
  logic [STATUS_W-1:0]   status_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [2:0]            phase_o;
  logic [1:0]            motor_write_o;
  logic [1:0]            timer_action_o;
  logic [TIMER_W-1:0]    timer_ms_o;
  logic [2:0]            issue_o;
  logic                  head_o;
  logic [CYL_W-1:0]      cylinder_o;
  logic [SECT_W-1:0]     sector_o;
  logic [ADDR_W-1:0]     xfer_addr_o;
  logic [SECT_W-1:0]     xfer_sectors_o;
  logic                  wake_o;
  logic [1:0]            error_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [TIMER_W-1:0]    cfg_data_i = '0;

  floppy_command_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .block_i        (block_i),
    .sectors_i      (sectors_i),
    .dma_addr_i     (dma_addr_i),
    .status_i       (status_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .phase_o        (phase_o),
    .motor_write_o  (motor_write_o),
    .timer_action_o (timer_action_o),
    .timer_ms_o     (timer_ms_o),
    .issue_o        (issue_o),
    .head_o         (head_o),
    .cylinder_o     (cylinder_o),
    .sector_o       (sector_o),
    .xfer_addr_o    (xfer_addr_o),
    .xfer_sectors_o (xfer_sectors_o),
    .wake_o         (wake_o),
    .error_o        (error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Drive model. It mirrors the sequencer's registers and is advanced once per
  // accepted event transfer, in the same order as the block sees them.
  // ---------------------------------------------------------------------------
  cfg_t                 regs_m;
  phase_e               phase_m;
  pend_e                pend_m;
  logic [RETRY_W-1:0]   retries_m;
  logic [BLOCK_W-1:0]   blk_m;
  logic [SECT_W-1:0]    cnt_m;
  logic [ADDR_W-1:0]    addr_m;

  // Results that the block owes us, oldest first.
  res_t awaited_replies[$];

  int send_idle_pct  = 26;
  int recv_stall_pct = 81;
  int n_errors       = 0;
  int n_events       = 0;
  int n_replies      = 0;
  int n_done         = 0;
  int n_io_err       = 0;
  int n_range_err    = 0;
  int quiet_cycles   = 0;

  function automatic void load_timer(inout res_t r, input logic [TIMER_W-1:0] ms);
    r.timer_action = TMR_LOAD;
    r.timer_ms     = ms;
  endfunction

  // Head and cylinder of the stored request block.
  function automatic void place_head(inout res_t r);
    r.head     = 1'((blk_m % PER_CYL) / SPT);
    r.cylinder = CYL_W'(blk_m / PER_CYL);
  endfunction

  function automatic void motor_off(inout res_t r);
    phase_m        = PH_OFF;
    r.motor_write  = MOTOR_OFF;
    r.timer_action = TMR_STOP;
    r.timer_ms     = '0;
  endfunction

  // An I/O error releases the requester but keeps the request stored.
  function automatic void io_error(inout res_t r);
    motor_off(r);
    r.wake  = 1'b1;
    r.error = ERR_IO;
  endfunction

  function automatic void ctrl_reset(inout res_t r);
    phase_m       = PH_RESET;
    r.motor_write = MOTOR_PULSE;
    load_timer(r, regs_m.reset_timeout_ms);
  endfunction

  function automatic void start_seek(inout res_t r);
    phase_m = PH_SEEK;
    load_timer(r, regs_m.seek_timeout_ms);
    r.issue = ISSUE_SEEK;
    place_head(r);
  endfunction

  // Seek and transfer trouble goes back through a controller reset until the
  // retry budget is spent; the count is left alone once it is.
  function automatic void retry_or_fail(inout res_t r);
    if (retries_m < regs_m.retry_limit) begin
      retries_m = retries_m + 1'b1;
      ctrl_reset(r);
    end else begin
      io_error(r);
    end
  endfunction

  function automatic res_t advance_drive(input logic [CMD_W-1:0] cmd,
                                         input logic [BLOCK_W-1:0] blk,
                                         input logic [SECT_W-1:0] cnt,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [STATUS_W-1:0] st);
    res_t r;
    r = '0;
    case (cmd)
      CMD_RD_REQ, CMD_WR_REQ: begin
        if (blk >= DISK_BLOCKS) begin
          // A block past the end of the disk is refused and changes nothing.
          r.wake  = 1'b1;
          r.error = ERR_RANGE;
        end else begin
          pend_m    = (cmd == CMD_WR_REQ) ? PEND_WRITE : PEND_READ;
          retries_m = '0;
          blk_m     = blk;
          cnt_m     = (cnt == '0) ? SECT_W'(1) : cnt;
          addr_m    = addr;
          if (phase_m == PH_OFF) begin
            phase_m       = PH_ON;
            r.motor_write = MOTOR_ON;
            load_timer(r, regs_m.spinup_ms);
          end else begin
            // A request while the drive is not off goes straight to seek.
            start_seek(r);
          end
        end
      end
      CMD_INTR: begin
        // Interrupts only matter from reset through transfer.
        if (phase_m >= PH_RESET && phase_m <= PH_XFER) begin
          if (pend_m == PEND_NONE) begin
            r.timer_action = TMR_STOP;
          end else begin
            case (phase_m)
              PH_RESET: begin
                phase_m = PH_RECAL;
                load_timer(r, regs_m.recal_timeout_ms);
                r.issue = ISSUE_RECAL;
              end
              PH_RECAL: begin
                if ((st & SEEK_ST_MASK) != SEEK_ST_OK) io_error(r);
                else start_seek(r);
              end
              PH_SEEK: begin
                if ((st & SEEK_ST_MASK) != SEEK_ST_OK) begin
                  retry_or_fail(r);
                end else begin
                  phase_m = PH_XFER;
                  load_timer(r, regs_m.xfer_timeout_ms);
                  r.issue        = (pend_m == PEND_WRITE) ? ISSUE_WRITE : ISSUE_READ;
                  place_head(r);
                  r.sector       = SECT_W'(blk_m % SPT + 1);
                  r.xfer_addr    = addr_m;
                  r.xfer_sectors = cnt_m;
                end
              end
              default: begin
                if ((st & XFER_ST_MASK) != '0) begin
                  retry_or_fail(r);
                end else begin
                  phase_m = PH_READY;
                  r.wake  = 1'b1;
                  load_timer(r, regs_m.idle_off_ms);
                end
              end
            endcase
          end
        end
      end
      CMD_TMO: begin
        case (phase_m)
          PH_ON:             ctrl_reset(r);
          PH_RESET, PH_RECAL: io_error(r);
          PH_SEEK, PH_XFER:  retry_or_fail(r);
          PH_READY:          motor_off(r);
          default:           ;
        endcase
      end
      CMD_CLOSE: begin
        pend_m = PEND_NONE;
        motor_off(r);
      end
      default: ;
    endcase
    r.phase = phase_m;
    return r;
  endfunction

  // A result with no head, cylinder or transfer fields, for the directed table.
  function automatic res_t fixed_reply(input phase_e ph, input motor_e mw, input tmr_e ta,
                                       input logic [TIMER_W-1:0] ms, input issue_e iss,
                                       input logic wk, input err_e er);
    res_t r;
    r              = '0;
    r.phase        = ph;
    r.motor_write  = mw;
    r.timer_action = ta;
    r.timer_ms     = ms;
    r.issue        = iss;
    r.wake         = wk;
    r.error        = er;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Event channel. Valid goes up at a rising edge and stays up, with a steady
  // payload, until the edge that takes the transfer. The model is stepped right
  // there, so the random generator below always sees the up-to-date phase.
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [BLOCK_W-1:0] blk,
                            input logic [SECT_W-1:0] cnt, input logic [ADDR_W-1:0] addr,
                            input logic [STATUS_W-1:0] st, input bit typed,
                            input res_t typed_reply);
    res_t modeled;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    block_i    <= blk;
    sectors_i  <= cnt;
    dma_addr_i <= addr;
    status_i   <= st;
    do @(posedge clk_i); while (in_stall_o);
    modeled = advance_drive(cmd, blk, cnt, addr, st);
    awaited_replies.push_back(typed ? typed_reply : modeled);
    n_events++;
    // Random gaps; the decision never looks at the stall input.
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stop sending, wait until every owed result is in and then let the block
  // settle, so that it is truly idle afterwards.
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes registers 0 .. count-1 back to back, mirroring each accepted write.
  task automatic program_regs(input logic [TIMER_W-1:0] vals [8], input int count);
    for (int i = 0; i < count; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (i)
        CFG_SPINUP:      regs_m.spinup_ms        = vals[i];
        CFG_RESET_TMO:   regs_m.reset_timeout_ms = vals[i];
        CFG_RECAL_TMO:   regs_m.recal_timeout_ms = vals[i];
        CFG_SEEK_TMO:    regs_m.seek_timeout_ms  = vals[i];
        CFG_XFER_TMO:    regs_m.xfer_timeout_ms  = vals[i];
        CFG_IDLE_OFF:    regs_m.idle_off_ms      = vals[i];
        CFG_RETRY_LIMIT: regs_m.retry_limit      = vals[i][RETRY_W-1:0];
        default:         ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result channel. Stall is redrawn every cycle; each transfer is compared
  // field by field with the oldest owed result.
  // ---------------------------------------------------------------------------
  res_t want_res;
  res_t seen_res;

  task automatic flag_field(input string name, input logic [ADDR_W-1:0] want,
                            input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        n_replies++;
        seen_res = {phase_o, motor_write_o, timer_action_o, timer_ms_o, issue_o, head_o,
                    cylinder_o, sector_o, xfer_addr_o, xfer_sectors_o, wake_o, error_o};
        if (awaited_replies.size() == 0) begin
          n_errors++;
          $display("%0t: result with nothing owed, expected none, actual 0x%0h",
                   $time, seen_res);
        end else begin
          want_res = awaited_replies.pop_front();
          if (want_res.wake && want_res.error == ERR_NONE) n_done++;
          if (want_res.error == ERR_IO) n_io_err++;
          if (want_res.error == ERR_RANGE) n_range_err++;
          flag_field("phase", ADDR_W'(want_res.phase), ADDR_W'(seen_res.phase));
          flag_field("motor_write", ADDR_W'(want_res.motor_write),
                     ADDR_W'(seen_res.motor_write));
          flag_field("timer_action", ADDR_W'(want_res.timer_action),
                     ADDR_W'(seen_res.timer_action));
          flag_field("timer_ms", ADDR_W'(want_res.timer_ms), ADDR_W'(seen_res.timer_ms));
          flag_field("issue", ADDR_W'(want_res.issue), ADDR_W'(seen_res.issue));
          flag_field("head", ADDR_W'(want_res.head), ADDR_W'(seen_res.head));
          flag_field("cylinder", ADDR_W'(want_res.cylinder), ADDR_W'(seen_res.cylinder));
          flag_field("sector", ADDR_W'(want_res.sector), ADDR_W'(seen_res.sector));
          flag_field("xfer_addr", want_res.xfer_addr, seen_res.xfer_addr);
          flag_field("xfer_sectors", ADDR_W'(want_res.xfer_sectors),
                     ADDR_W'(seen_res.xfer_sectors));
          flag_field("wake", ADDR_W'(want_res.wake), ADDR_W'(seen_res.wake));
          flag_field("error", ADDR_W'(want_res.error), ADDR_W'(seen_res.error));
        end
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count of quiet cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still owed",
                 $time, WATCHDOG_LIMIT, awaited_replies.size());
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: one row per event. Rows whose result is obvious carry it
  // typed in; the rest are checked against the drive model.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [BLOCK_W-1:0]  blk;
    logic [SECT_W-1:0]   cnt;
    logic [ADDR_W-1:0]   addr;
    logic [STATUS_W-1:0] st;
    bit                  typed;
    res_t                reply;
  } script_row_t;

  script_row_t script_rows[$];

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [BLOCK_W-1:0] blk,
                         input logic [SECT_W-1:0] cnt, input logic [ADDR_W-1:0] addr,
                         input logic [STATUS_W-1:0] st, input bit typed, input res_t reply);
    script_row_t row;
    row.cmd   = cmd;
    row.blk   = blk;
    row.cnt   = cnt;
    row.addr  = addr;
    row.st    = st;
    row.typed = typed;
    row.reply = reply;
    script_rows.push_back(row);
  endtask

  initial begin : stimulus
    logic [TIMER_W-1:0]  wr_vals [8];
    logic [CMD_W-1:0]    ev_cmd;
    logic [CMD_W-1:0]    req_cmd;
    logic [BLOCK_W-1:0]  ev_blk;
    logic [SECT_W-1:0]   ev_cnt;
    logic [ADDR_W-1:0]   ev_addr;
    logic [STATUS_W-1:0] ev_st;
    res_t                idle_off;
    res_t                io_fail;
    res_t                spin_up;
    res_t                shut_off;
    int                  roll;
    int                  pick;
    int                  wr_count;

    regs_m    = '{SPINUP_RST, RESET_TMO_RST, RECAL_TMO_RST, SEEK_TMO_RST,
                  XFER_TMO_RST, IDLE_OFF_RST, RETRY_LIMIT_RST};
    phase_m   = PH_OFF;
    pend_m    = PEND_NONE;
    retries_m = '0;
    blk_m     = '0;
    cnt_m     = '0;
    addr_m    = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_off = fixed_reply(PH_OFF, MOTOR_NONE, TMR_LEAVE, '0, ISSUE_NONE, 1'b0, ERR_NONE);
    io_fail  = fixed_reply(PH_OFF, MOTOR_OFF, TMR_STOP, '0, ISSUE_NONE, 1'b1, ERR_IO);
    spin_up  = fixed_reply(PH_ON, MOTOR_ON, TMR_LOAD, SPINUP_RST, ISSUE_NONE, 1'b0, ERR_NONE);
    shut_off = fixed_reply(PH_OFF, MOTOR_OFF, TMR_STOP, '0, ISSUE_NONE, 1'b0, ERR_NONE);

    // Right after reset the drive is off, so stray events are ignored.
    add_row(CMD_INTR, '0, '0, '0, '0, 1'b1, idle_off);
    add_row(CMD_TMO, '0, '0, '0, '0, 1'b1, idle_off);
    add_row(CMD_SPARE_HI, '0, '0, '0, '0, 1'b1, idle_off);
    // Blocks past the end of the disk, at the top and just over the edge.
    add_row(CMD_RD_REQ, BLOCK_W'(BLOCK_MAX), 5'd1, '0, '0, 1'b1,
            fixed_reply(PH_OFF, MOTOR_NONE, TMR_LEAVE, '0, ISSUE_NONE, 1'b1, ERR_RANGE));
    add_row(CMD_WR_REQ, BLOCK_W'(DISK_BLOCKS), 5'd1, '0, '0, 1'b1,
            fixed_reply(PH_OFF, MOTOR_NONE, TMR_LEAVE, '0, ISSUE_NONE, 1'b1, ERR_RANGE));
    // Last block with a zero length, all the way to ready.
    add_row(CMD_RD_REQ, BLOCK_W'(DISK_BLOCKS - 1), '0, '1, '0, 1'b1, spin_up);
    add_row(CMD_INTR, '0, '0, '0, '1, 1'b1,
            fixed_reply(PH_ON, MOTOR_NONE, TMR_LEAVE, '0, ISSUE_NONE, 1'b0, ERR_NONE));
    add_row(CMD_TMO, '0, '0, '0, '0, 1'b1,
            fixed_reply(PH_RESET, MOTOR_PULSE, TMR_LOAD, RESET_TMO_RST, ISSUE_NONE,
                        1'b0, ERR_NONE));
    add_row(CMD_INTR, '0, '0, '0, '0, 1'b1,
            fixed_reply(PH_RECAL, MOTOR_NONE, TMR_LOAD, RECAL_TMO_RST, ISSUE_RECAL,
                        1'b0, ERR_NONE));
    add_row(CMD_INTR, '0, '0, '0, 8'h27, 1'b0, '0);
    add_row(CMD_INTR, '0, '0, '0, SEEK_ST_OK, 1'b0, '0);
    add_row(CMD_INTR, '0, '0, '0, 8'h27, 1'b0, '0);
    add_row(CMD_INTR, '0, '0, '0, '0, 1'b1,
            fixed_reply(PH_READY, MOTOR_NONE, TMR_LEAVE, '0, ISSUE_NONE, 1'b0, ERR_NONE));
    // New write while ready goes to seek; a bad seek retries, then times out.
    add_row(CMD_WR_REQ, '0, '1, '0, '0, 1'b0, '0);
    add_row(CMD_INTR, '0, '0, '0, '1, 1'b0, '0);
    add_row(CMD_TMO, '0, '0, '0, '0, 1'b1, io_fail);
    add_row(CMD_CLOSE, '0, '0, '0, '0, 1'b1, shut_off);
    add_row(CMD_WR_REQ, 12'd1234, 5'd18, 24'h123456, '0, 1'b1, spin_up);
    add_row(CMD_CLOSE, '0, '0, '0, '0, 1'b1, shut_off);
    add_row(CMD_SPARE_LO, '1, '1, '1, '1, 1'b1, idle_off);
    // A failed recalibrate is an I/O error at once, with no retry.
    add_row(CMD_RD_REQ, BLOCK_W'(PER_CYL), 5'd9, 24'h00a5c3, '0, 1'b0, '0);
    add_row(CMD_TMO, '0, '0, '0, '0, 1'b0, '0);
    add_row(CMD_INTR, '0, '0, '0, '0, 1'b0, '0);
    add_row(CMD_INTR, '0, '0, '0, '0, 1'b1, io_fail);

    foreach (script_rows[k]) begin
      send_event(script_rows[k].cmd, script_rows[k].blk, script_rows[k].cnt,
                 script_rows[k].addr, script_rows[k].st, script_rows[k].typed,
                 script_rows[k].reply);
    end
    drain_replies();

    // Three random passes, each with its own registers and idle pattern:
    // all timers zero and no retries, all ones (retry limit masked to seven),
    // then random values plus a write to the unused register slot.
    for (int pass = 0; pass < 3; pass++) begin
      wr_count = 7;
      case (pass)
        0: begin
          send_idle_pct  = 26;
          recv_stall_pct = 81;
          foreach (wr_vals[i]) wr_vals[i] = '0;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 26;
          foreach (wr_vals[i]) wr_vals[i] = '1;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          foreach (wr_vals[i]) wr_vals[i] = TIMER_W'($urandom);
          wr_vals[CFG_RETRY_LIMIT] = TIMER_W'($urandom_range(6, 1));
          wr_count = 8;
        end
      endcase
      program_regs(wr_vals, wr_count);

      for (int n = 0; n < RANDOM_PER_PASS; n++) begin
        // Halfway through, hold off until the block has answered everything.
        if (n == RANDOM_PER_PASS / 2) drain_replies();

        pick = $urandom_range(99, 0);
        if (pick < 6) ev_blk = BLOCK_W'($urandom_range(BLOCK_MAX, DISK_BLOCKS));
        else if (pick < 8) ev_blk = '0;
        else if (pick < 10) ev_blk = BLOCK_W'(DISK_BLOCKS - 1);
        else ev_blk = BLOCK_W'($urandom_range(DISK_BLOCKS - 1, 0));
        ev_cnt  = ($urandom_range(99, 0) < 80) ? SECT_W'($urandom_range(SPT, 1))
                                                : SECT_W'($urandom_range(31, 0));
        ev_addr = ADDR_W'($urandom);
        ev_st   = STATUS_W'($urandom);
        req_cmd = $urandom_range(1, 0) ? CMD_WR_REQ : CMD_RD_REQ;

        // Mostly the event that moves the current phase forward, with a good
        // status where one is needed; the rest is failures and plain noise.
        roll = $urandom_range(99, 0);
        if (roll < 12) begin
          ev_cmd = CMD_W'($urandom_range(CMD_SPARE_HI, 0));
        end else begin
          case (phase_m)
            PH_ON: begin
              if (roll < 80) ev_cmd = CMD_TMO;
              else if (roll < 88) ev_cmd = req_cmd;
              else if (roll < 94) ev_cmd = CMD_INTR;
              else ev_cmd = CMD_CLOSE;
            end
            PH_RESET: begin
              if (roll < 85) ev_cmd = CMD_INTR;
              else if (roll < 94) ev_cmd = CMD_TMO;
              else ev_cmd = CMD_CLOSE;
            end
            PH_RECAL, PH_SEEK: begin
              if (roll < 76) begin
                ev_cmd = CMD_INTR;
                ev_st  = SEEK_ST_OK | (ev_st & ~SEEK_ST_MASK);
              end else if (roll < 88) begin
                ev_cmd = CMD_INTR;
              end else if (roll < 95) begin
                ev_cmd = CMD_TMO;
              end else begin
                ev_cmd = (phase_m == PH_SEEK) ? req_cmd : CMD_CLOSE;
              end
            end
            PH_XFER: begin
              if (roll < 76) begin
                ev_cmd = CMD_INTR;
                ev_st  = ev_st & ~XFER_ST_MASK;
              end else if (roll < 88) begin
                ev_cmd = CMD_INTR;
              end else if (roll < 95) begin
                ev_cmd = CMD_TMO;
              end else begin
                ev_cmd = CMD_CLOSE;
              end
            end
            PH_READY: begin
              if (roll < 50) ev_cmd = req_cmd;
              else if (roll < 75) ev_cmd = CMD_TMO;
              else if (roll < 88) ev_cmd = CMD_CLOSE;
              else ev_cmd = CMD_INTR;
            end
            default: begin
              if (roll < 90) ev_cmd = req_cmd;
              else if (roll < 95) ev_cmd = CMD_CLOSE;
              else ev_cmd = CMD_TMO;
            end
          endcase
        end
        send_event(ev_cmd, ev_blk, ev_cnt, ev_addr, ev_st, 1'b0, '0);
      end
      drain_replies();
    end

    $display("Sent %0d events and checked %0d results under four register settings.",
             n_events, n_replies);
    $display("Seen: %0d completed transfers, %0d I/O errors, %0d out-of-range requests.",
             n_done, n_io_err, n_range_err);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
